// File: sv/lrp_pkg.sv
package lrp_pkg;

  localparam int CNT_W = 32;
  localparam int CFG_W = 5;
  localparam int IN_PAGE_W = 16;
  localparam int OUT_COUNT_W = 5;
  localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd16;

  typedef struct packed {
    logic hit;
    logic evict;
  } cell_cmd_t;

endpackage

// File: sv/lru_page_replacement.sv
// channel   direction  beat                 handshake
// in        input      page_number          in_valid / in_stall
// out       output     was_hit .. misses    out_valid / out_stall
// cfg       input      frames_in_use        cfg_we / cfg_wdata
//
// one reference per cycle while in_stall is low; the result is registered and appears in the cycle after acceptance
// the rate is set by the cell row: all cells compare and shift together in the same cycle
// in_stall rises only while a result waits under out_stall
// synchronous reset empties the row, clears totals and sets 16 frames
module lru_page_replacement #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [lrp_pkg::IN_PAGE_W-1:0]     page_number,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              was_hit,
  output logic                              did_evict,
  output logic [lrp_pkg::IN_PAGE_W-1:0]     evicted_page,
  output logic [lrp_pkg::OUT_COUNT_W-1:0]   resident_count,
  output logic [lrp_pkg::CNT_W-1:0]         total_hits,
  output logic [lrp_pkg::CNT_W-1:0]         total_misses,
  input  logic                              cfg_we,
  input  logic [lrp_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int OCC_W = $clog2(FRAMES + 1);

  logic [lrp_pkg::CFG_W-1:0] frames_in_use;
  logic [OCC_W-1:0]          occupancy;
  logic [OCC_W-1:0]          occupancy_next;
  logic [31:0]               cap;
  logic                      step;
  logic [PAGE_BITS-1:0]      key;
  lrp_pkg::cell_cmd_t        cmd;
  logic [PAGE_BITS-1:0]      cell_page [FRAMES];
  logic [PAGE_BITS-1:0]      cell_tail [FRAMES];
  logic [FRAMES-1:0]         valid_vec;
  logic [FRAMES-1:0]         match_vec;
  logic [FRAMES-1:0]         hit_from;
  logic [PAGE_BITS-1:0]      tail_word;

  assign in_stall = out_valid && out_stall;
  assign step     = in_valid && !in_stall;
  assign key      = PAGE_BITS'(page_number);

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= lrp_pkg::FRAMES_RESET;
    end else if (cfg_we) begin
      frames_in_use <= cfg_wdata;
    end
  end

  always_comb begin
    if (frames_in_use == '0) begin
      cap = 32'd1;
    end else if (32'(frames_in_use) > 32'(FRAMES)) begin
      cap = 32'(FRAMES);
    end else begin
      cap = 32'(frames_in_use);
    end
  end

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      hit_from[i] = (match_vec >> i) != '0;
    end
  end

  always_comb begin
    tail_word = '0;
    for (int i = 0; i < FRAMES; i++) begin
      tail_word = tail_word | cell_tail[i];
    end
  end

  assign cmd.hit   = |match_vec;
  assign cmd.evict = !cmd.hit && (32'(occupancy) >= cap);

  always_comb begin
    occupancy_next = occupancy;
    if (!cmd.hit && !cmd.evict) begin
      occupancy_next = occupancy + 1'b1;
    end
  end

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    logic [PAGE_BITS-1:0] prev_page;
    logic                 prev_valid;
    logic                 next_valid;

    if (i == 0) begin : g_head
      assign prev_page  = key;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_page  = cell_page[i-1];
      assign prev_valid = valid_vec[i-1];
    end

    if (i == FRAMES - 1) begin : g_tail
      assign next_valid = 1'b0;
    end else begin : g_mid
      assign next_valid = valid_vec[i+1];
    end

    lrp_cell #(
      .PAGE_BITS(PAGE_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .step      (step),
      .cmd       (cmd),
      .key       (key),
      .prev_page (prev_page),
      .prev_valid(prev_valid),
      .next_valid(next_valid),
      .hit_from  (hit_from[i]),
      .page      (cell_page[i]),
      .valid     (valid_vec[i]),
      .match     (match_vec[i]),
      .tail_page (cell_tail[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        occupancy <= occupancy_next;
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      was_hit      <= cmd.hit;
      did_evict    <= cmd.evict;
      evicted_page <= cmd.evict ? lrp_pkg::IN_PAGE_W'(tail_word) : '0;
    end
  end

  assign resident_count = lrp_pkg::OUT_COUNT_W'(occupancy);

  lrp_sat_counter u_hits (
    .clk  (clk),
    .rst  (rst),
    .inc  (step && cmd.hit),
    .count(total_hits)
  );

  lrp_sat_counter u_misses (
    .clk  (clk),
    .rst  (rst),
    .inc  (step && !cmd.hit),
    .count(total_misses)
  );

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    32'(occupancy) <= 32'(FRAMES))
    else $error("occupancy above frame count");

  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == 32'(occupancy))
    else $error("valid cells disagree with occupancy");

  a_single_match: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match_vec))
    else $error("page resident in more than one cell");

  a_evict_keeps_occ: assert property (@(posedge clk) disable iff (rst)
    step && cmd.evict |=> $stable(occupancy) && did_evict && !was_hit)
    else $error("eviction changed occupancy or result flags");

  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    step |=> valid_vec[0] && (cell_page[0] == $past(key)))
    else $error("referenced page not most recent");
`endif

endmodule

// File: sv/lrp_cell.sv
module lrp_cell #(
  parameter int PAGE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  lrp_pkg::cell_cmd_t    cmd,
  input  logic [PAGE_BITS-1:0]  key,
  input  logic [PAGE_BITS-1:0]  prev_page,
  input  logic                  prev_valid,
  input  logic                  next_valid,
  input  logic                  hit_from,
  output logic [PAGE_BITS-1:0]  page,
  output logic                  valid,
  output logic                  match,
  output logic [PAGE_BITS-1:0]  tail_page
);

  logic shift;

  // take the neighbor's entry when this slot lies inside the moved span
  always_comb begin
    if (cmd.hit) begin
      shift = hit_from;
    end else if (cmd.evict) begin
      shift = valid;
    end else begin
      shift = prev_valid;
    end
  end

  assign match     = valid && (page == key);
  assign tail_page = (valid && !next_valid) ? page : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (step && shift) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && shift) begin
      page <= prev_page;
    end
  end

endmodule

// File: sv/lrp_sat_counter.sv
module lrp_sat_counter (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      inc,
  output logic [lrp_pkg::CNT_W-1:0] count
);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (inc && (count != '1)) begin
      count <= count + 1'b1;
    end
  end

endmodule

// File: bench/tb_lru_page_replacement.sv
`timescale 1ns / 100ps
module tb_lru_page_replacement;

  localparam int NUM_FRAMES = 16;
  localparam int POOL_SIZE = 24;

  typedef struct packed {
    logic                            hit;
    logic                            evict;
    logic [lrp_pkg::IN_PAGE_W-1:0]   evicted;
    logic [lrp_pkg::OUT_COUNT_W-1:0] resident;
    logic [lrp_pkg::CNT_W-1:0]       hits;
    logic [lrp_pkg::CNT_W-1:0]       misses;
  } access_result_t;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            in_valid;
  logic                            in_stall;
  logic [lrp_pkg::IN_PAGE_W-1:0]   page_number;
  logic                            out_valid;
  logic                            out_stall;
  logic                            was_hit;
  logic                            did_evict;
  logic [lrp_pkg::IN_PAGE_W-1:0]   evicted_page;
  logic [lrp_pkg::OUT_COUNT_W-1:0] resident_count;
  logic [lrp_pkg::CNT_W-1:0]       total_hits;
  logic [lrp_pkg::CNT_W-1:0]       total_misses;
  logic                            cfg_we;
  logic [lrp_pkg::CFG_W-1:0]       cfg_wdata;

  // predictor state
  logic [lrp_pkg::IN_PAGE_W-1:0] recent_pages [NUM_FRAMES];
  logic                          recent_valid [NUM_FRAMES];
  int unsigned                   resident_pages;
  logic [lrp_pkg::CNT_W-1:0]     hit_total;
  logic [lrp_pkg::CNT_W-1:0]     miss_total;
  logic [lrp_pkg::CFG_W-1:0]     frame_setting;

  access_result_t expected_results [$];
  access_result_t head_result;
  int errors;
  int items_sent;
  int results_seen;
  int configs_written;
  int send_idle_pct;
  int recv_idle_pct;

  lru_page_replacement uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .page_number   (page_number),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .was_hit       (was_hit),
    .did_evict     (did_evict),
    .evicted_page  (evicted_page),
    .resident_count(resident_count),
    .total_hits    (total_hits),
    .total_misses  (total_misses),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic access_result_t predict_access(
    input logic [lrp_pkg::IN_PAGE_W-1:0] pg
  );
    access_result_t r;
    int unsigned    limit;
    int             found;
    int             last;
    r = '0;
    limit = 32'(frame_setting);
    if (limit == 0) limit = 1;
    if (limit > NUM_FRAMES) limit = NUM_FRAMES;
    found = -1;
    for (int i = 0; i < resident_pages; i++) begin
      if (found < 0 && recent_valid[i] && recent_pages[i] == pg) found = i;
    end
    if (found >= 0) begin
      r.hit = 1'b1;
      last = found;
      if (hit_total != '1) hit_total++;
    end else begin
      if (resident_pages < limit) begin
        last = resident_pages;
        resident_pages++;
      end else begin
        r.evict = 1'b1;
        r.evicted = recent_pages[resident_pages-1];
        last = resident_pages - 1;
      end
      if (miss_total != '1) miss_total++;
    end
    for (int i = last; i > 0; i--) begin
      if (i < NUM_FRAMES) begin
        recent_pages[i] = recent_pages[i-1];
        recent_valid[i] = recent_valid[i-1];
      end
    end
    recent_pages[0] = pg;
    recent_valid[0] = 1'b1;
    r.resident = resident_pages[lrp_pkg::OUT_COUNT_W-1:0];
    r.hits = hit_total;
    r.misses = miss_total;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual hit=%0b page=%0h",
                 $time, was_hit, evicted_page);
      end else begin
        head_result = expected_results.pop_front();
        check_field("was_hit", 32'(head_result.hit), 32'(was_hit));
        check_field("did_evict", 32'(head_result.evict), 32'(did_evict));
        check_field("evicted_page", 32'(head_result.evicted), 32'(evicted_page));
        check_field("resident_count", 32'(head_result.resident), 32'(resident_count));
        check_field("total_hits", head_result.hits, total_hits);
        check_field("total_misses", head_result.misses, total_misses);
      end
      results_seen++;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic send_page(input logic [lrp_pkg::IN_PAGE_W-1:0] pg);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    page_number <= pg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(predict_access(pg));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_frames(input logic [lrp_pkg::CFG_W-1:0] value);
    wait_for_results();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    frame_setting = value;
    configs_written++;
  endtask

  // zero frames acts as one
  task automatic test_zero_and_one_frame();
    write_frames(5'd0);
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'hFFFF);
    write_frames(5'd1);
    send_page(16'hAAAA);
    send_page(16'h5555);
  endtask

  task automatic test_partial_fill();
    write_frames(5'd3);
    send_page(16'h0001);
    send_page(16'h0002);
    send_page(16'h5555);
    send_page(16'h0003);
  endtask

  // oversized setting clamps to the full row
  task automatic test_full_fill();
    write_frames(5'd31);
    for (int p = 16'h0010; p <= 16'h001C; p++) send_page(p[lrp_pkg::IN_PAGE_W-1:0]);
    write_frames(5'd16);
    send_page(16'hFFFF);
    send_page(16'h0010);
  endtask

  // pages stay resident, each miss still evicts one
  task automatic test_shrink_below_occupancy();
    write_frames(5'd2);
    send_page(16'h7FFF);
    send_page(16'h7FFF);
    send_page(16'h8000);
  endtask

  task automatic test_random_traffic(input int count, input int sender_idle,
                                     input int receiver_idle,
                                     input logic [lrp_pkg::CFG_W-1:0] frames);
    logic [lrp_pkg::IN_PAGE_W-1:0] pool [POOL_SIZE];
    logic [lrp_pkg::IN_PAGE_W-1:0] pg;
    int                            span;
    write_frames(frames);
    send_idle_pct = sender_idle;
    recv_idle_pct = receiver_idle;
    foreach (pool[i]) pool[i] = lrp_pkg::IN_PAGE_W'($urandom);
    span = $urandom_range(POOL_SIZE, 10);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(9) == 0) pg = lrp_pkg::IN_PAGE_W'($urandom);
      else pg = pool[$urandom_range(span-1)];
      send_page(pg);
      if (k == count / 2) wait_for_results();
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    page_number = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    configs_written = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    foreach (recent_pages[i]) begin
      recent_pages[i] = '0;
      recent_valid[i] = 1'b0;
    end
    resident_pages = 0;
    hit_total = '0;
    miss_total = '0;
    frame_setting = lrp_pkg::FRAMES_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_zero_and_one_frame();
    test_partial_fill();
    test_full_fill();
    test_shrink_below_occupancy();
    test_random_traffic(330, 28, 77, 5'd17);
    test_random_traffic(330, 77, 28, 5'd8);
    test_random_traffic(340, 0, 0, 5'd16);

    in_valid <= 1'b0;
    for (int guard = 0; guard < 10000 && expected_results.size() != 0; guard++) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
    if (expected_results.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, expected_results.size());
    end

    $display("covered %0d page references (%0d hits, %0d misses) over %0d frame settings",
             items_sent, hit_total, miss_total, configs_written);
    $display("%0d result beats checked, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("[lru_page_replacement] OK");
    end else begin
      $display("[lru_page_replacement] ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout");
    $display("[lru_page_replacement] ERROR");
    $finish;
  end

endmodule
